FILE: hw/rtl/rational_arith_unit_top_defines.svh
`ifndef RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rau check failed");

`endif

FILE: hw/rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;
  localparam int unsigned DW = 32;
  localparam int unsigned PW = 2 * DW;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rau_mul.sv
`default_nettype none
module rau_mul (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [rau_pkg::DW-1:0]       a_i,
  input  wire  [rau_pkg::DW-1:0]       b_i,
  output logic                         done_o,
  output logic [rau_pkg::PW-1:0]       prod_o
);
  localparam int unsigned CW = $clog2(rau_pkg::DW);

  logic [rau_pkg::DW-1:0] hi_q, lo_q, mc_q;
  logic [CW-1:0]          cnt_q;
  logic                   busy_q, done_q;
  logic [rau_pkg::DW:0]   sum;

  assign sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? mc_q : '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(rau_pkg::DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      mc_q <= a_i;
    end else if (busy_q) begin
      hi_q <= sum[rau_pkg::DW:1];
      lo_q <= {sum[0], lo_q[rau_pkg::DW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};
endmodule
`default_nettype wire

FILE: hw/rtl/rau_div.sv
`default_nettype none
module rau_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [rau_pkg::PW-1:0]       num_i,
  input  wire  [rau_pkg::PW-1:0]       den_i,
  output logic                         done_o,
  output logic [rau_pkg::PW-1:0]       quo_o
);
  localparam int unsigned CW = $clog2(rau_pkg::PW);

  logic [rau_pkg::PW-1:0] rem_q, quo_q, den_q;
  logic [CW-1:0]          cnt_q;
  logic                   busy_q, done_q;
  logic [rau_pkg::PW:0]   sh, diff;
  logic                   fit;

  assign sh   = {rem_q, quo_q[rau_pkg::PW-1]};
  assign diff = sh - {1'b0, den_q};
  assign fit  = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(rau_pkg::PW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fit ? diff[rau_pkg::PW-1:0] : sh[rau_pkg::PW-1:0];
      quo_q <= {quo_q[rau_pkg::PW-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rau_gcd.sv
`default_nettype none
module rau_gcd (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [rau_pkg::PW-1:0]       a_i,
  input  wire  [rau_pkg::PW-1:0]       b_i,
  output logic                         done_o,
  output logic [rau_pkg::PW-1:0]       gcd_o
);
  localparam int unsigned KW = $clog2(rau_pkg::PW);

  logic [rau_pkg::PW-1:0] u_q, v_q;
  logic [KW-1:0]          k_q;
  logic                   run_q, shl_q, done_q;
  logic [rau_pkg::PW-1:0] u_m_v, v_m_u;

  assign u_m_v = u_q - v_q;
  assign v_m_u = v_q - u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      shl_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && (u_q == '0 || v_q == '0)) begin
        run_q <= 1'b0;
        shl_q <= 1'b1;
      end else if (shl_q && k_q == '0) begin
        shl_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= a_i;
      v_q <= b_i;
      k_q <= '0;
    end else if (run_q) begin
      if (u_q == '0 || v_q == '0) begin
        v_q <= u_q | v_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_m_v >> 1;
      end else begin
        v_q <= v_m_u >> 1;
      end
    end else if (shl_q && k_q != '0) begin
      v_q <= v_q << 1;
      k_q <= k_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign gcd_o  = v_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rational_arith_unit_top.sv
// channel | signals                                           | dir
// in      | in_valid_i, in_ready_o, req_type_i, a_/b_ num/den | in
// out     | out_valid_o, out_ready_i, res_num_o, res_den_o,   | out
//         | status_o                                          |
// One word at a time; ready in idle, also while a result waits.
// Add/sub: gcd, two divides, then three multiplies. Mul/div: two
// multiplies, gcd over 64 bits, then two divides. Errors go straight
// to the result. The bit-serial gcd, divider and multiplier set how
// long a request takes.
// Reset clears control only; a stalled result holds the sequencer.
`default_nettype none
module rational_arith_unit_top #(
  parameter int unsigned WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [1:0]                    req_type_i,
  input  wire  signed [rau_pkg::DW-1:0] a_num_i,
  input  wire  signed [rau_pkg::DW-1:0] a_den_i,
  input  wire  signed [rau_pkg::DW-1:0] b_num_i,
  input  wire  signed [rau_pkg::DW-1:0] b_den_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [rau_pkg::DW-1:0] res_num_o,
  output logic signed [rau_pkg::DW-1:0] res_den_o,
  output logic [1:0]                    status_o
);
  localparam int unsigned DW = rau_pkg::DW;
  localparam int unsigned PW = rau_pkg::PW;
  localparam int unsigned VW = PW + 2;

  localparam logic signed [VW-1:0] FitHi = (VW'(1) <<< (WIDTH - 1)) - VW'(1);
  localparam logic signed [VW-1:0] FitLo = -FitHi - VW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_MUL3 = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV1 = 3'd5;
  localparam logic [2:0] S_DIV2 = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic          launched_q;
  logic [1:0]    op_q, st_q;
  logic          sn_q, sd_q;
  logic [DW-1:0] ma_q, mad_q, mb_q, mbd_q;
  logic [PW-1:0] g_q, p1_q, p2_q, q1_q, q2_q;
  logic          out_valid_q;
  logic [DW-1:0] res_num_q, res_den_q;
  logic [1:0]    status_q;

  logic          addsub, accept, in_err;
  logic [1:0]    in_st;
  rau_pkg::unit_ctl_t mul_ctl, div_ctl, gcd_ctl;
  logic [DW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p, div_n, div_d, div_q, gcd_a, gcd_b, gcd_r;
  logic          unit_done, launch, fin_go;
  logic signed [VW-1:0] vn, vd, t1, t2;
  logic          ok;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    mag = x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [VW-1:0] apply_sign(input logic s,
                                                      input logic [PW-1:0] m);
    apply_sign = s ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  assign addsub = (op_q == rau_pkg::OP_ADD) || (op_q == rau_pkg::OP_SUB);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    in_st = rau_pkg::ST_OK;
    if (a_den_i == '0 || b_den_i == '0) begin
      in_st = rau_pkg::ST_ZDEN;
    end else if (req_type_i == rau_pkg::OP_DIV && b_num_i == '0) begin
      in_st = rau_pkg::ST_DIVZ;
    end
  end
  assign in_err = (in_st != rau_pkg::ST_OK);

  assign launch = !launched_q && state_q != S_IDLE && state_q != S_FIN;

  always_comb begin
    mul_a = ma_q;
    mul_b = mbd_q;
    unique case (state_q)
      S_MUL1: begin
        mul_a = addsub ? q1_q[DW-1:0] : ma_q;
        mul_b = addsub ? mbd_q : ((op_q == rau_pkg::OP_MUL) ? mb_q : mbd_q);
      end
      S_MUL2: begin
        mul_a = addsub ? ma_q : mad_q;
        mul_b = addsub ? q2_q[DW-1:0] : ((op_q == rau_pkg::OP_MUL) ? mbd_q : mb_q);
      end
      S_MUL3: begin
        mul_a = mb_q;
        mul_b = q1_q[DW-1:0];
      end
      default: begin
        mul_a = ma_q;
        mul_b = mbd_q;
      end
    endcase
  end

  assign gcd_a = addsub ? {{DW{1'b0}}, mad_q} : p1_q;
  assign gcd_b = addsub ? {{DW{1'b0}}, mbd_q} : p2_q;
  assign div_n = (state_q == S_DIV1) ? (addsub ? {{DW{1'b0}}, mad_q} : p1_q)
                                     : (addsub ? {{DW{1'b0}}, mbd_q} : p2_q);
  assign div_d = g_q;

  assign mul_ctl.start = launch &&
    (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3);
  assign div_ctl.start = launch && (state_q == S_DIV1 || state_q == S_DIV2);
  assign gcd_ctl.start = launch && (state_q == S_GCD);

  rau_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_ctl.start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_ctl.done), .prod_o(mul_p)
  );
  rau_div u_div (
    .clk_i, .rst_ni, .start_i(div_ctl.start), .num_i(div_n), .den_i(div_d),
    .done_o(div_ctl.done), .quo_o(div_q)
  );
  rau_gcd u_gcd (
    .clk_i, .rst_ni, .start_i(gcd_ctl.start), .a_i(gcd_a), .b_i(gcd_b),
    .done_o(gcd_ctl.done), .gcd_o(gcd_r)
  );

  assign unit_done = mul_ctl.done || div_ctl.done || gcd_ctl.done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_err) begin
            state_d = S_FIN;
          end else if (req_type_i == rau_pkg::OP_ADD || req_type_i == rau_pkg::OP_SUB) begin
            state_d = S_GCD;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_GCD:  if (unit_done) state_d = S_DIV1;
      S_DIV1: if (unit_done) state_d = S_DIV2;
      S_DIV2: if (unit_done) state_d = addsub ? S_MUL1 : S_FIN;
      S_MUL1: if (unit_done) state_d = S_MUL2;
      S_MUL2: if (unit_done) state_d = addsub ? S_MUL3 : S_GCD;
      S_MUL3: if (unit_done) state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign t1 = apply_sign(sn_q, p2_q);
  assign t2 = apply_sign(sd_q, g_q);
  always_comb begin
    if (addsub) begin
      vn = t1 + t2;
      vd = $signed({2'b00, p1_q});
    end else begin
      vn = apply_sign(sn_q, q1_q);
      vd = apply_sign(sd_q, q2_q);
    end
  end
  assign ok = (vn >= FitLo) && (vn <= FitHi) && (vd >= FitLo) && (vd <= FitHi);
  assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (launch) begin
        launched_q <= 1'b1;
      end else if (unit_done) begin
        launched_q <= 1'b0;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_type_i;
      st_q  <= in_st;
      ma_q  <= mag(a_num_i);
      mad_q <= mag(a_den_i);
      mb_q  <= mag(b_num_i);
      mbd_q <= mag(b_den_i);
      unique case (req_type_i)
        rau_pkg::OP_ADD: begin
          sn_q <= a_num_i[DW-1] ^ a_den_i[DW-1];
          sd_q <= b_num_i[DW-1] ^ b_den_i[DW-1];
        end
        rau_pkg::OP_SUB: begin
          sn_q <= a_num_i[DW-1] ^ a_den_i[DW-1];
          sd_q <= ~(b_num_i[DW-1] ^ b_den_i[DW-1]);
        end
        rau_pkg::OP_MUL: begin
          sn_q <= a_num_i[DW-1] ^ b_num_i[DW-1];
          sd_q <= a_den_i[DW-1] ^ b_den_i[DW-1];
        end
        default: begin
          sn_q <= a_num_i[DW-1] ^ b_den_i[DW-1];
          sd_q <= a_den_i[DW-1] ^ b_num_i[DW-1];
        end
      endcase
    end
    if (mul_ctl.done) begin
      unique case (state_q)
        S_MUL1:  p1_q <= mul_p;
        S_MUL2:  p2_q <= mul_p;
        default: g_q  <= mul_p;
      endcase
    end
    if (gcd_ctl.done) begin
      g_q <= gcd_r;
    end
    if (div_ctl.done) begin
      if (state_q == S_DIV1) begin
        q1_q <= div_q;
      end else begin
        q2_q <= div_q;
      end
    end
    if (fin_go) begin
      if (st_q != rau_pkg::ST_OK) begin
        status_q  <= st_q;
        res_num_q <= '0;
        res_den_q <= '0;
      end else if (!ok) begin
        status_q  <= rau_pkg::ST_OVF;
        res_num_q <= '0;
        res_den_q <= '0;
      end else begin
        status_q  <= rau_pkg::ST_OK;
        res_num_q <= vn[DW-1:0];
        res_den_q <= vd[DW-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign status_o    = status_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rau_checker.sv
`default_nettype none
`include "rational_arith_unit_top_defines.svh"
module rau_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_o,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input wire signed [rau_pkg::DW-1:0] res_num_o,
  input wire signed [rau_pkg::DW-1:0] res_den_o,
  input wire [1:0]                    status_o
);
  logic err_out, ok_out;

  assign err_out = out_valid_o && (status_o != rau_pkg::ST_OK);
  assign ok_out  = out_valid_o && (status_o == rau_pkg::ST_OK);

  `RAU_ASSERT_NOW(a_err_zero, clk_i, rst_ni, err_out, res_num_o == '0 && res_den_o == '0)
  `RAU_ASSERT_NOW(a_ok_den, clk_i, rst_ni, ok_out, res_den_o != '0)
  `RAU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(res_num_o) && $stable(res_den_o) && $stable(status_o))
  `RAU_ASSERT_NEXT(a_one_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .res_num_o, .res_den_o, .status_o
);
`default_nettype wire
